### sv/lbs2d_pkg.sv
// ----------------------------------------------------------------------------
// lbs2d_pkg
// Shared types, widths and codes of the 2D linear blend skinning block.
// ----------------------------------------------------------------------------
package lbs2d_pkg;

    localparam int MAT_FRAC_BITS    = 12;
    localparam int WEIGHT_FRAC_BITS = 16;

    localparam int COORD_W  = 32;
    localparam int MAT_W    = 16;
    localparam int WEIGHT_W = 17;
    localparam int VX_W     = COORD_W + 1;
    localparam int PSUM_W   = 51;
    localparam int PX_W     = PSUM_W - MAT_FRAC_BITS;
    localparam int OPA_W    = PX_W;
    localparam int OPB_W    = WEIGHT_W + 1;
    localparam int PROD_W   = OPA_W + OPB_W;
    localparam int WT_W     = PROD_W - WEIGHT_FRAC_BITS;
    localparam int ACC_W    = 64;
    localparam int FIN_W    = ACC_W + 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SKELETON_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKELETON_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_OFFSETS = 2'd2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] OUT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] OUT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0]  vert_x;
        logic signed [COORD_W-1:0]  vert_y;
        logic signed [COORD_W-1:0]  offset_x;
        logic signed [COORD_W-1:0]  offset_y;
        logic        [WEIGHT_W-1:0] influence_weight;
        logic signed [MAT_W-1:0]    mat_a;
        logic signed [MAT_W-1:0]    mat_b;
        logic signed [MAT_W-1:0]    mat_c;
        logic signed [MAT_W-1:0]    mat_d;
        logic signed [COORD_W-1:0]  bone_tx;
        logic signed [COORD_W-1:0]  bone_ty;
        logic                       last_influence;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
    } out_word_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL_X,
        OP_MUL_Y,
        OP_SUM_Y,
        OP_WEIGHT,
        OP_ACCUM,
        OP_FINAL
    } dp_op_t;

    typedef struct packed {
        logic   load;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

### sv/lbs2d_in_if.sv
// ----------------------------------------------------------------------------
// lbs2d_in_if
// Valid/ready channel carrying one bone influence word.
// ----------------------------------------------------------------------------
interface lbs2d_in_if import lbs2d_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/lbs2d_out_if.sv
// ----------------------------------------------------------------------------
// lbs2d_out_if
// Valid/ready channel carrying one skinned vertex word.
// ----------------------------------------------------------------------------
interface lbs2d_out_if import lbs2d_pkg::*; ();
    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/lbs2d_ctrl.sv
// ----------------------------------------------------------------------------
// lbs2d_ctrl
// Sequencer stepping the datapath through one influence at a time.
// ----------------------------------------------------------------------------
module lbs2d_ctrl import lbs2d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SUM_Y,
        ST_WEIGHT,
        ST_ACCUM,
        ST_FINAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:
            begin
                cmd.op     = OP_MUL_X;
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                cmd.op     = OP_MUL_Y;
                state_next = ST_SUM_Y;
            end
            ST_SUM_Y:
            begin
                cmd.op     = OP_SUM_Y;
                state_next = ST_WEIGHT;
            end
            ST_WEIGHT:
            begin
                cmd.op     = OP_WEIGHT;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.op     = OP_ACCUM;
                state_next = status.last ? ST_FINAL : ST_IDLE;
            end
            ST_FINAL:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_FINAL;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/lbs2d_dp.sv
// ----------------------------------------------------------------------------
// lbs2d_dp
// Operand registers, shared multiplier pair, accumulators and output word.
// ----------------------------------------------------------------------------
module lbs2d_dp import lbs2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_word_t              in_data,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output out_word_t             out_data
);

    logic signed [COORD_W-1:0]  skel_x_reg;
    logic signed [COORD_W-1:0]  skel_y_reg;
    logic                       use_off_reg;

    logic signed [VX_W-1:0]     vx_reg;
    logic signed [VX_W-1:0]     vy_reg;
    logic signed [MAT_W-1:0]    ma_reg;
    logic signed [MAT_W-1:0]    mb_reg;
    logic signed [MAT_W-1:0]    mc_reg;
    logic signed [MAT_W-1:0]    md_reg;
    logic signed [COORD_W-1:0]  tx_reg;
    logic signed [COORD_W-1:0]  ty_reg;
    logic        [WEIGHT_W-1:0] w_reg;
    logic                       last_reg;

    logic signed [PROD_W-1:0]   prod0_reg;
    logic signed [PROD_W-1:0]   prod1_reg;
    logic signed [PX_W-1:0]     px_reg;
    logic signed [PX_W-1:0]     py_reg;
    logic signed [ACC_W-1:0]    sum_x_reg;
    logic signed [ACC_W-1:0]    sum_y_reg;
    logic signed [ACC_W-1:0]    sum_x_next;
    logic signed [ACC_W-1:0]    sum_y_next;

    logic signed [COORD_W-1:0]  out_x_reg;
    logic signed [COORD_W-1:0]  out_y_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    logic signed [VX_W-1:0]     vx_load;
    logic signed [VX_W-1:0]     vy_load;
    logic signed [OPA_W-1:0]    opa0;
    logic signed [OPA_W-1:0]    opa1;
    logic signed [OPB_W-1:0]    opb0;
    logic signed [OPB_W-1:0]    opb1;
    logic signed [PROD_W-1:0]   mul0;
    logic signed [PROD_W-1:0]   mul1;
    logic signed [COORD_W-1:0]  t_sel;
    logic signed [PSUM_W-1:0]   psum;
    logic signed [OPB_W-1:0]    w_op;

    function automatic logic signed [ACC_W-1:0] sat_acc(
        input logic signed [ACC_W-1:0] s,
        input logic signed [WT_W-1:0]  v
    );
        logic signed [ACC_W:0] t;
        t = (ACC_W+1)'(s) + (ACC_W+1)'(v);
        if (t[ACC_W] != t[ACC_W-1])
        begin
            return t[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return t[ACC_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_out(
        input logic signed [ACC_W-1:0]   s,
        input logic signed [COORD_W-1:0] k
    );
        logic signed [FIN_W-1:0] t;
        t = FIN_W'(s) + FIN_W'(k);
        if (t > FIN_W'(OUT_MAX))
        begin
            return OUT_MAX;
        end
        if (t < FIN_W'(OUT_MIN))
        begin
            return OUT_MIN;
        end
        return t[COORD_W-1:0];
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skel_x_reg  <= '0;
            skel_y_reg  <= '0;
            use_off_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SKELETON_X:  skel_x_reg  <= cfg_data;
                CFG_SKELETON_Y:  skel_y_reg  <= cfg_data;
                CFG_USE_OFFSETS: use_off_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        vx_load = VX_W'(in_data.vert_x);
        vy_load = VX_W'(in_data.vert_y);
        if (use_off_reg)
        begin
            vx_load = VX_W'(in_data.vert_x) + VX_W'(in_data.offset_x);
            vy_load = VX_W'(in_data.vert_y) + VX_W'(in_data.offset_y);
        end
    end

    assign w_op = $signed({1'b0, w_reg});

    // multiplier operand select
    always_comb
    begin
        opa0 = OPA_W'(vx_reg);
        opa1 = OPA_W'(vy_reg);
        opb0 = OPB_W'(ma_reg);
        opb1 = OPB_W'(mb_reg);
        unique case (cmd.op)
            OP_MUL_Y:
            begin
                opb0 = OPB_W'(mc_reg);
                opb1 = OPB_W'(md_reg);
            end
            OP_WEIGHT:
            begin
                opa0 = px_reg;
                opa1 = py_reg;
                opb0 = w_op;
                opb1 = w_op;
            end
            default:
            begin
            end
        endcase
    end

    assign mul0 = opa0 * opb0;
    assign mul1 = opa1 * opb1;

    assign t_sel = (cmd.op == OP_MUL_Y) ? tx_reg : ty_reg;
    assign psum  = PSUM_W'(prod0_reg) + PSUM_W'(prod1_reg)
                 + (PSUM_W'(t_sel) <<< MAT_FRAC_BITS);

    assign sum_x_next = sat_acc(sum_x_reg, prod0_reg[PROD_W-1:WEIGHT_FRAC_BITS]);
    assign sum_y_next = sat_acc(sum_y_reg, prod1_reg[PROD_W-1:WEIGHT_FRAC_BITS]);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vx_reg <= vx_load;
            vy_reg <= vy_load;
            ma_reg <= in_data.mat_a;
            mb_reg <= in_data.mat_b;
            mc_reg <= in_data.mat_c;
            md_reg <= in_data.mat_d;
            tx_reg <= in_data.bone_tx;
            ty_reg <= in_data.bone_ty;
            w_reg  <= in_data.influence_weight;
        end
        if (cmd.op == OP_MUL_X || cmd.op == OP_MUL_Y || cmd.op == OP_WEIGHT)
        begin
            prod0_reg <= mul0;
            prod1_reg <= mul1;
        end
        if (cmd.op == OP_MUL_Y)
        begin
            px_reg <= psum[PSUM_W-1:MAT_FRAC_BITS];
        end
        if (cmd.op == OP_SUM_Y)
        begin
            py_reg <= psum[PSUM_W-1:MAT_FRAC_BITS];
        end
        if (cmd.op == OP_FINAL)
        begin
            out_x_reg <= sat_out(sum_x_reg, skel_x_reg);
            out_y_reg <= sat_out(sum_y_reg, skel_y_reg);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == OP_FINAL)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                last_reg <= in_data.last_influence;
            end
            if (cmd.op == OP_ACCUM)
            begin
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
            end
            else if (cmd.op == OP_FINAL)
            begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
            end
        end
    end

    assign status.last     = last_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign out_data.world_x = out_x_reg;
    assign out_data.world_y = out_y_reg;

    a_final_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FINAL |-> (!out_valid_reg || out_ready))
        else $error("output word overwritten");

    a_final_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FINAL |=> out_valid_reg)
        else $error("finished vertex not presented");

    a_final_clears_sums: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FINAL |=> (sum_x_reg == '0 && sum_y_reg == '0))
        else $error("accumulators not cleared after vertex");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> cmd.op == OP_NONE)
        else $error("load during a datapath step");

endmodule

### sv/linear_blend_skinning_2d.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning_2d
// 2D linear blend skinning: transforms each bone influence of a vertex,
// weights it, accumulates, and emits the saturated sum plus skeleton origin.
// ----------------------------------------------------------------------------
//  channel    dir  word        handshake
//  influence  in   in_word_t   valid/ready
//  vertex     out  out_word_t  valid/ready
//  cfg        in   index/data  cfg_we, no back-pressure
//
//  an influence steps through MUL_X, MUL_Y, SUM_Y, WEIGHT and ACCUM from
//  acceptance until the next can be taken, one marked last also through FINAL,
//  while the shared multiplier pair steps through the matrix rows, then weights
//  the finished vertex sits in an output register; a stalled vertex channel
//  holds the block only when the next vertex is ready to be written out
//  reset clears accumulators, configuration and the output valid flag
// ----------------------------------------------------------------------------
module linear_blend_skinning_2d import lbs2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lbs2d_in_if.sink              influence,
    lbs2d_out_if.source           vertex
);

    dp_cmd_t    cmd;
    dp_status_t status;

    lbs2d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (influence.valid),
        .in_ready (influence.ready),
        .status   (status),
        .cmd      (cmd)
    );

    lbs2d_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (influence.data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (vertex.ready),
        .out_valid (vertex.valid),
        .out_data  (vertex.data)
    );

endmodule

### verif/tb_linear_blend_skinning_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_blend_skinning_2d
// Self-checking bench for the 2D skinning block. A short table of hand-made
// influences runs first at reset configuration. It is followed by several
// configuration phases of random vertices with random gaps and stalls on both
// channels. Every vertex word is checked against a hand-typed value or an
// in-bench model of the transform, weighting, accumulation and saturation.
// ----------------------------------------------------------------------------
module tb_linear_blend_skinning_2d;
    import lbs2d_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int NUM_PHASES  = 7;
    localparam int PHASE_ITEMS = 70;
    localparam int SETTLE      = 20;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PRINT_LIMIT = 40;

    typedef struct {
        in_word_t  word;
        bit        known;
        out_word_t vertex;
    } bench_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lbs2d_in_if  influence_if ();
    lbs2d_out_if vertex_if ();

    linear_blend_skinning_2d u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .influence (influence_if),
        .vertex    (vertex_if)
    );

    // model state
    longint    acc_x = 0;
    longint    acc_y = 0;
    longint    skel_x = 0;
    longint    skel_y = 0;
    bit        offsets_on = 1'b0;

    out_word_t  expected_vertices[$];
    bench_row_t directed_rows[$];
    int         errors = 0;
    int         influence_words = 0;
    int         vertex_words = 0;
    int         idle_cycles = 0;
    bit         src_quiet = 1'b0;
    bit         snk_quiet = 1'b0;

    always #5 clk = ~clk;

    function automatic longint sat_add64(input longint a, input longint b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            return s[64] ? ACC_MIN : ACC_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic [31:0] clamp32(input longint r);
        if (r > OUT_MAX)
        begin
            return OUT_MAX;
        end
        if (r < OUT_MIN)
        begin
            return OUT_MIN;
        end
        return r[31:0];
    endfunction

    // transform, weight and accumulate one influence; returns 1 with a vertex on last
    function automatic bit skin_influence(input in_word_t w, output out_word_t vtx);
        longint vx, vy, ox, oy, tx, ty, wt, ma, mb, mc, md, px, py;
        vx = w.vert_x;
        vy = w.vert_y;
        ox = w.offset_x;
        oy = w.offset_y;
        tx = w.bone_tx;
        ty = w.bone_ty;
        wt = w.influence_weight;
        ma = w.mat_a;
        mb = w.mat_b;
        mc = w.mat_c;
        md = w.mat_d;
        if (offsets_on)
        begin
            vx = vx + ox;
            vy = vy + oy;
        end
        px = (vx * ma + vy * mb + (tx <<< MAT_FRAC_BITS)) >>> MAT_FRAC_BITS;
        py = (vx * mc + vy * md + (ty <<< MAT_FRAC_BITS)) >>> MAT_FRAC_BITS;
        acc_x = sat_add64(acc_x, (px * wt) >>> WEIGHT_FRAC_BITS);
        acc_y = sat_add64(acc_y, (py * wt) >>> WEIGHT_FRAC_BITS);
        vtx = '0;
        if (!w.last_influence)
        begin
            return 1'b0;
        end
        vtx.world_x = clamp32(sat_add64(acc_x, skel_x));
        vtx.world_y = clamp32(sat_add64(acc_y, skel_y));
        acc_x = 0;
        acc_y = 0;
        return 1'b1;
    endfunction

    function automatic in_word_t influence_word(
        input logic [31:0] vx, input logic [31:0] vy,
        input logic [31:0] ox, input logic [31:0] oy,
        input logic [16:0] wt,
        input logic [15:0] a, input logic [15:0] b,
        input logic [15:0] c, input logic [15:0] d,
        input logic [31:0] tx, input logic [31:0] ty,
        input logic last);
        in_word_t w;
        w.vert_x           = vx;
        w.vert_y           = vy;
        w.offset_x         = ox;
        w.offset_y         = oy;
        w.influence_weight = wt;
        w.mat_a            = a;
        w.mat_b            = b;
        w.mat_c            = c;
        w.mat_d            = d;
        w.bone_tx          = tx;
        w.bone_ty          = ty;
        w.last_influence   = last;
        return w;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 11))
            0: return OUT_MAX;
            1: return OUT_MIN;
            2: return '0;
            3: return '1;
            4, 5: return $urandom();
            default: return $urandom_range(0, 33554431) - 32'd16777216;
        endcase
    endfunction

    function automatic logic [15:0] rand_mat();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return '0;
            3, 4: return 16'($urandom());
            default: return 16'($urandom_range(0, 16383) - 8192);
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 17'h1FFFF;
            2: return 17'h10000;
            3: return 17'($urandom());
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= PRINT_LIMIT)
        begin
            $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
        end
    endtask

    task automatic add_row(input in_word_t w, input bit known,
                           input logic [31:0] ex, input logic [31:0] ey);
        bench_row_t r;
        r.word           = w;
        r.known          = known;
        r.vertex.world_x = ex;
        r.vertex.world_y = ey;
        directed_rows.push_back(r);
    endtask

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send_word(input in_word_t w, input bit known, input out_word_t typed);
        int        gap;
        out_word_t vtx;
        if ($urandom_range(0, 39) == 0)
        begin
            src_quiet = !src_quiet;
        end
        gap = src_quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            influence_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        influence_if.data  <= w;
        influence_if.valid <= 1'b1;
        do @(posedge clk); while (!influence_if.ready);
        influence_words++;
        if (skin_influence(w, vtx))
        begin
            expected_vertices.push_back(known ? typed : vtx);
        end
    endtask

    task automatic send_vertex(inout int count);
        int       n;
        in_word_t w;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            w = influence_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                               rand_weight(), rand_mat(), rand_mat(), rand_mat(), rand_mat(),
                               rand_coord(), rand_coord(),
                               (i == n - 1) || ($urandom_range(0, 19) == 0));
            send_word(w, 1'b0, '0);
            count++;
        end
    endtask

    task automatic finish_phase();
        influence_if.valid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_config(input logic [31:0] sx, input logic [31:0] sy, input bit off);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx = '{CFG_SKELETON_X, CFG_SKELETON_Y, CFG_USE_OFFSETS, CFG_SPARE};
        val = '{sx, sy, {31'($urandom()), off}, $urandom()};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            case (idx[i])
                CFG_SKELETON_X:  skel_x = $signed(val[i]);
                CFG_SKELETON_Y:  skel_y = $signed(val[i]);
                CFG_USE_OFFSETS: offsets_on = val[i][0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // vertex sink and checker
    initial
    begin
        int        stall;
        out_word_t want;
        vertex_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                snk_quiet = !snk_quiet;
            end
            stall = snk_quiet ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                vertex_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            vertex_if.ready <= 1'b1;
            do @(posedge clk); while (!vertex_if.valid);
            vertex_words++;
            if (expected_vertices.size() == 0)
            begin
                report("vertex word with nothing pending", vertex_if.data.world_x, '0);
            end
            else
            begin
                want = expected_vertices.pop_front();
                if (vertex_if.data.world_x !== want.world_x)
                begin
                    report("world_x", vertex_if.data.world_x, want.world_x);
                end
                if (vertex_if.data.world_y !== want.world_y)
                begin
                    report("world_y", vertex_if.data.world_y, want.world_y);
                end
            end
        end
    end

    // no progress on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((influence_if.valid && influence_if.ready) || (vertex_if.valid && vertex_if.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles, %0d vertex words pending",
                         IDLE_LIMIT, expected_vertices.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int phase_items;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        influence_if.valid <= 1'b0;
        influence_if.data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: no origin, offsets ignored
        add_row(influence_word(32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               17'h10000, 16'h1000, 16'h0, 16'h0, 16'h1000, 32'h0, 32'h0, 1'b1),
                1'b1, 32'h0001_0000, 32'h0002_0000);
        add_row(influence_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 17'h1FFFF,
                               16'h7FFF, 16'h0, 16'h0, 16'h7FFF,
                               32'h7FFF_FFFF, 32'h8000_0000, 1'b1),
                1'b1, OUT_MAX, OUT_MIN);
        add_row(influence_word(32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 32'h0, 17'h0,
                               16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                               32'h7FFF_FFFF, 32'h8000_0000, 1'b1),
                1'b1, 32'h0, 32'h0);
        // floor of negative values
        add_row(influence_word(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 17'h10000,
                               16'h0001, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 1'b1),
                1'b1, 32'hFFFF_FFFF, 32'h0);
        add_row(influence_word(32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0, 17'h1,
                               16'h1000, 16'h0, 16'h0, 16'h1000, 32'h0, 32'h0, 1'b1),
                1'b1, 32'h0, 32'hFFFF_FFFF);
        add_row(influence_word(32'h0, 32'h0, 32'h0, 32'h0, 17'h10000,
                               16'h0, 16'h0, 16'h0, 16'h0, 32'h1234_0000, 32'hEDCC_0000, 1'b1),
                1'b1, 32'h1234_0000, 32'hEDCC_0000);
        add_row(influence_word(32'h0, 32'h0, 32'h0, 32'h0, 17'h1FFFF,
                               16'h0, 16'h0, 16'h0, 16'h0, 32'h8000_0000, 32'h8000_0000, 1'b1),
                1'b1, OUT_MIN, OUT_MIN);
        // three influences summing to one
        add_row(influence_word(32'h0003_8000, 32'hFFFE_4000, 32'h0, 32'h0, 17'h08000,
                               16'h0B50, 16'hF4B0, 16'h0B50, 16'h0B50,
                               32'h0010_0000, 32'hFFF0_0000, 1'b0), 1'b0, '0, '0);
        add_row(influence_word(32'h0003_8000, 32'hFFFE_4000, 32'h0, 32'h0, 17'h04000,
                               16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                               32'h0000_0001, 32'hFFFF_FFFF, 1'b0), 1'b0, '0, '0);
        add_row(influence_word(32'h0003_8000, 32'hFFFE_4000, 32'h0, 32'h0, 17'h04000,
                               16'h1000, 16'h0800, 16'hF800, 16'h1000,
                               32'h0020_0000, 32'h0030_0000, 1'b1), 1'b0, '0, '0);
        add_row(influence_word('1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1),
                1'b0, '0, '0);
        add_row(influence_word('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1),
                1'b1, 32'h0, 32'h0);
        add_row(influence_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 17'h1FFFF,
                               16'h8000, 16'h8000, 16'h8000, 16'h8000,
                               32'h0, 32'h0, 1'b0), 1'b0, '0, '0);
        add_row(influence_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 17'h0,
                               16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1), 1'b0, '0, '0);
        add_row(influence_word(32'hFFF3_2000, 32'h0005_6000, 32'h0, 32'h0, 17'h18000,
                               16'h0E00, 16'hFA00, 16'h0600, 16'h0E00,
                               32'hFFFF_0000, 32'h0001_8000, 1'b1), 1'b0, '0, '0);

        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].vertex);
        end
        finish_phase();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: write_config(32'h0, 32'h0, 1'b1);
                1: write_config(OUT_MAX, OUT_MIN, 1'b1);
                2: write_config(OUT_MIN, OUT_MAX, 1'b0);
                3: write_config(rand_coord(), rand_coord(), 1'b1);
                default: write_config($urandom(), $urandom(), 1'($urandom_range(0, 1)));
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) send_vertex(phase_items);
            finish_phase();
        end

        if (expected_vertices.size() != 0)
        begin
            report("vertex words never produced", expected_vertices.size(), '0);
        end
        $display("run: %0d influence words, %0d vertex words over %0d register settings",
                 influence_words, vertex_words, NUM_PHASES + 1);
        $display("      (reset values, origin extremes, offsets on and off), %0d mismatches",
                 errors);
        if (errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
sv/lbs2d_pkg.sv
sv/lbs2d_in_if.sv
sv/lbs2d_out_if.sv
sv/lbs2d_ctrl.sv
sv/lbs2d_dp.sv
sv/linear_blend_skinning_2d.sv
verif/tb_linear_blend_skinning_2d.sv
